>>> rtl/sigmoid_step_rate_ramp_core_macros.svh
`ifndef SIGMOID_STEP_RATE_RAMP_CORE_MACROS_SVH
`define SIGMOID_STEP_RATE_RAMP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define SSRR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssrr: assertion failed");

// Next-cycle implication.
`define SSRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssrr: assertion failed");

`endif

>>> rtl/ssrr_pkg.sv
package ssrr_pkg;

  // Sizing
  localparam int WINDOW_LEN         = 40;
  localparam int RAMP_HALF_STEPS    = 20;
  localparam int COUNTS_PER_PERCENT = 418;
  localparam int FULL_SCALE_PCT     = 100;
  localparam int SIG_HALF           = 20;   // half span of the fixed sigmoid table
  localparam int SIG_LEN            = 2 * SIG_HALF + 1;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PTR_W     = $clog2(WINDOW_LEN);
  localparam int SUM_W     = DATA_W + $clog2(WINDOW_LEN);
  localparam int POS_W     = $clog2(RAMP_HALF_STEPS + 2) + 1;
  localparam int SIG_IDX_W = $clog2(SIG_LEN);
  localparam int PCT_W     = $clog2(FULL_SCALE_PCT + 1);
  localparam int PROD_W    = DATA_W + PCT_W;

  // Reciprocals for exact floor division by constants: x / d == (x * m) >> k
  localparam int MEAN_K  = SUM_W + $clog2(WINDOW_LEN);
  localparam int MEAN_RW = SUM_W + 1;
  localparam logic [MEAN_RW-1:0] MEAN_RECIP =
    MEAN_RW'(((64'd1 << MEAN_K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam int PCT_K  = DATA_W + $clog2(COUNTS_PER_PERCENT);
  localparam int PCT_RW = DATA_W + 1;
  localparam logic [PCT_RW-1:0] PCT_RECIP =
    PCT_RW'(((64'd1 << PCT_K) + 64'(COUNTS_PER_PERCENT) - 64'd1) / 64'(COUNTS_PER_PERCENT));

  localparam int DIV_K  = PROD_W + $clog2(FULL_SCALE_PCT);
  localparam int DIV_RW = PROD_W + 1;
  localparam logic [DIV_RW-1:0] DIV_RECIP =
    DIV_RW'(((64'd1 << DIV_K) + 64'(FULL_SCALE_PCT) - 64'd1) / 64'(FULL_SCALE_PCT));

  localparam logic signed [POS_W-1:0] POS_HALF     = POS_W'(RAMP_HALF_STEPS);
  localparam logic signed [POS_W-1:0] POS_NEG_HALF = POS_W'(-RAMP_HALF_STEPS);
  localparam logic signed [POS_W-1:0] POS_ONE      = POS_W'(1);

  // Register map and reset values
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_RATE    = CFG_IDX_W'(1);
  localparam logic [DATA_W-1:0]    CHANGE_THRESHOLD_RST = DATA_W'(1000);
  localparam logic [DATA_W-1:0]    MAX_STEP_RATE_RST    = DATA_W'(12000);

  // Request kinds
  localparam logic FUNC_CONTROL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] adc_sample;
    logic              up_pressed;
    logic              down_pressed;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] step_rate;
    logic              pulses_on;
    logic              motor_enabled;
    logic              direction_down;
    logic              ramp_active;
  } rsp_t;

  typedef struct packed {
    logic run;
    logic fall;
    logic susp;
    logic up_latch;
    logic dn_latch;
    logic en;
    logic dir;
  } flags_t;

  localparam flags_t FLAGS_RST = '{run: 1'b0, fall: 1'b0, susp: 1'b1, up_latch: 1'b0,
                                   dn_latch: 1'b0, en: 1'b0, dir: 1'b0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_CHECK,
    ST_PCT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Q16 logistic curve, 65536 / (1 + exp(-0.2 t)), t = -20..20
  function automatic logic [DATA_W-1:0] sig_weight(input logic [SIG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] w;
    case (idx)
      6'd0:  w = 16'd1179;
      6'd1:  w = 16'd1434;
      6'd2:  w = 16'd1743;
      6'd3:  w = 16'd2117;
      6'd4:  w = 16'd2567;
      6'd5:  w = 16'd3108;
      6'd6:  w = 16'd3757;
      6'd7:  w = 16'd4531;
      6'd8:  w = 16'd5451;
      6'd9:  w = 16'd6537;
      6'd10: w = 16'd7812;
      6'd11: w = 16'd9296;
      6'd12: w = 16'd11009;
      6'd13: w = 16'd12964;
      6'd14: w = 16'd15170;
      6'd15: w = 16'd17625;
      6'd16: w = 16'd20318;
      6'd17: w = 16'd23222;
      6'd18: w = 16'd26300;
      6'd19: w = 16'd29502;
      6'd20: w = 16'd32768;
      6'd21: w = 16'd36034;
      6'd22: w = 16'd39236;
      6'd23: w = 16'd42314;
      6'd24: w = 16'd45218;
      6'd25: w = 16'd47911;
      6'd26: w = 16'd50366;
      6'd27: w = 16'd52572;
      6'd28: w = 16'd54527;
      6'd29: w = 16'd56240;
      6'd30: w = 16'd57724;
      6'd31: w = 16'd58999;
      6'd32: w = 16'd60085;
      6'd33: w = 16'd61005;
      6'd34: w = 16'd61779;
      6'd35: w = 16'd62428;
      6'd36: w = 16'd62969;
      6'd37: w = 16'd63419;
      6'd38: w = 16'd63793;
      6'd39: w = 16'd64102;
      6'd40: w = 16'd64357;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/sigmoid_step_rate_ramp_core.sv
// Stepper speed controller with an S-curve rate ramp. A control request (func 0) pushes
// one knob sample into a 40-sample sliding window and reads the up/down buttons; while a
// button is held and no ramp runs, the truncated window mean selects a target of
// percent x max_step_rate (percent = mean / 418, capped at 100), taken only when the mean
// has moved by more than change_threshold or has dropped below one percent with a
// nonzero target. Releasing the buttons ramps down to zero. A tick request (func 1)
// moves the running ramp one point along a 41-point Q16 sigmoid. Every request gives
// exactly one response: current rate and drive flags.
// Timing: ticks, control requests with no button held and control requests during a
// ramp finish straight from idle, and a new request is accepted every cycle while the
// response register drains. A control request with a button held and no ramp running
// goes through a short sequencer: window mean, change check, then, when it takes a new
// target, percent, scaling and divide by 100, then done; the mean, percent and divide
// use reciprocal multiplies. in_ready is low meanwhile. The window lives in a RAM whose
// oldest entry is prefetched one request ahead; per-entry valid bits give the zero
// contents after reset, so there is no clearing pass. Configuration is written with
// cfg_we, taking effect on the next request; write it only while the block is idle.
module sigmoid_step_rate_ramp_core import ssrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data
);

  // config
  logic [DATA_W-1:0] change_threshold;
  logic [DATA_W-1:0] max_step_rate;

  // request holding register
  req_t req;
  logic req_vld;

  state_t state, state_next;

  // sample window
  logic [DATA_W-1:0]     win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_vld;
  logic [PTR_W-1:0]      win_ptr, win_ptr_next;
  logic [SUM_W-1:0]      win_sum, win_sum_next;
  logic [DATA_W-1:0]     old_data;   // prefetched win_mem[win_ptr]
  logic                  old_vld;
  logic [DATA_W-1:0]     oldest;

  // speed state
  logic [DATA_W-1:0]        last_level, last_level_next;
  logic [DATA_W-1:0]        target_rate, target_rate_next;
  logic [DATA_W-1:0]        present_rate, present_rate_next;
  logic [DATA_W-1:0]        origin_rate, origin_rate_next;
  logic signed [POS_W-1:0]  ramp_pos, ramp_pos_next;
  flags_t                   flags, flags_next;

  // sequencer datapath registers
  logic [DATA_W-1:0] mean_q, mean_q_next;
  logic [PCT_W-1:0]  pct_q, pct_q_next;
  logic [PROD_W-1:0] prod_q, prod_q_next;

  // handshake control
  logic is_tick, btn, long_pass, out_free, step_go, win_go, complete, take;

  // arithmetic
  logic [SUM_W+MEAN_RW-1:0]   mean_prod;
  logic [DATA_W-1:0]          mean_calc;
  logic [2*DATA_W:0]          pct_prod;
  logic [2*DATA_W:0]          pct_shift;
  logic [PROD_W+DIV_RW-1:0]   div_prod;
  logic [DATA_W-1:0]          div_tgt;
  logic [DATA_W-1:0]          lvl_diff;
  logic [SIG_IDX_W-1:0]       sig_idx;
  logic [DATA_W-1:0]          sig_w;
  logic                       tgt_above;
  logic [DATA_W-1:0]          span;
  logic [2*DATA_W-1:0]        span_prod;
  logic [DATA_W-1:0]          curve;
  logic [DATA_W:0]            fall_sum;
  logic signed [POS_W-1:0]    pos_inc, pos_dec;

  assign is_tick   = (req.func == FUNC_TICK);
  assign btn       = req.up_pressed | req.down_pressed;
  assign long_pass = req_vld && !is_tick && btn && !flags.run;
  assign out_free  = !out_valid || out_ready;

  // requests served straight from idle, and the sequencer's entry
  assign step_go  = (state == ST_IDLE) && req_vld && !long_pass && out_free;
  assign win_go   = (state == ST_IDLE) && req_vld && !is_tick && (long_pass || out_free);
  assign complete = step_go || ((state == ST_DONE) && out_free);
  assign in_ready = !req_vld || complete;

  assign oldest = old_vld ? old_data : '0;

  // --- arithmetic ---------------------------------------------------------
  always_comb begin
    // window mean from the registered sum
    mean_prod = (SUM_W+MEAN_RW)'(win_sum) * (SUM_W+MEAN_RW)'(MEAN_RECIP);
    mean_calc = DATA_W'(mean_prod >> MEAN_K);

    // percent of full scale
    pct_prod  = (2*DATA_W+1)'(mean_q) * (2*DATA_W+1)'(PCT_RECIP);
    pct_shift = pct_prod >> PCT_K;

    // scaled product / 100
    div_prod = (PROD_W+DIV_RW)'(prod_q) * (PROD_W+DIV_RW)'(DIV_RECIP);
    div_tgt  = DATA_W'(div_prod >> DIV_K);

    lvl_diff = (mean_q > last_level) ? (mean_q - last_level) : (last_level - mean_q);
    take     = (lvl_diff > change_threshold) ||
               ((mean_q < DATA_W'(COUNTS_PER_PERCENT)) && (target_rate != '0));

    // sigmoid lookup, position clamped to the table
    if (ramp_pos < -SIG_HALF) begin
      sig_idx = '0;
    end else if (ramp_pos > SIG_HALF) begin
      sig_idx = SIG_IDX_W'(SIG_LEN - 1);
    end else begin
      sig_idx = SIG_IDX_W'(ramp_pos + SIG_HALF);
    end
    sig_w = sig_weight(sig_idx);

    // origin is only added back when climbing towards a higher target
    tgt_above = target_rate > origin_rate;
    span      = tgt_above ? (target_rate - origin_rate) : (origin_rate - target_rate);
    span_prod = (2*DATA_W)'(span) * (2*DATA_W)'(sig_w);
    curve     = span_prod[2*DATA_W-1:DATA_W] + (tgt_above ? origin_rate : '0);
    fall_sum  = (DATA_W+1)'(target_rate) + (DATA_W+1)'(curve);

    pos_inc = ramp_pos + POS_ONE;
    pos_dec = ramp_pos - POS_ONE;
  end

  // --- sequencer next state -------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  begin
        if (long_pass) state_next = ST_MEAN;
      end
      ST_MEAN:  state_next = ST_CHECK;
      ST_CHECK: state_next = take ? ST_PCT : ST_DONE;
      ST_PCT:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_DONE;
      ST_DONE:  begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // --- state updates --------------------------------------------------------
  always_comb begin
    win_ptr_next      = win_ptr;
    win_sum_next      = win_sum;
    last_level_next   = last_level;
    target_rate_next  = target_rate;
    present_rate_next = present_rate;
    origin_rate_next  = origin_rate;
    ramp_pos_next     = ramp_pos;
    flags_next        = flags;
    mean_q_next       = mean_q;
    pct_q_next        = pct_q;
    prod_q_next       = prod_q;

    if (win_go) begin
      win_sum_next = win_sum - SUM_W'(oldest) + SUM_W'(req.adc_sample);
      win_ptr_next = (win_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : win_ptr + PTR_W'(1);
    end

    case (state)
      ST_IDLE: begin
        if (long_pass) begin
          // up wins when both are held
          if (req.up_pressed) begin
            flags_next.dir      = 1'b0;
            flags_next.up_latch = 1'b1;
          end else begin
            flags_next.dir      = 1'b1;
            flags_next.dn_latch = 1'b1;
          end
        end else if (step_go && !is_tick) begin
          // buttons released after a press: ramp down to zero
          if (!btn && (flags.up_latch || flags.dn_latch)) begin
            target_rate_next    = '0;
            ramp_pos_next       = POS_HALF;
            flags_next.run      = 1'b1;
            flags_next.fall     = 1'b1;
            flags_next.up_latch = 1'b0;
            flags_next.dn_latch = 1'b0;
          end
        end else if (step_go && flags.run) begin
          if (flags.fall) begin
            present_rate_next = fall_sum[DATA_W] ? '1 : fall_sum[DATA_W-1:0];
            ramp_pos_next     = pos_dec;
            if (pos_dec < POS_NEG_HALF) begin
              if (target_rate != '0) begin
                if (flags.susp) begin
                  flags_next.en   = 1'b1;
                  flags_next.susp = 1'b0;
                end
                flags_next.run    = 1'b0;
                origin_rate_next  = target_rate;
                present_rate_next = target_rate;
              end else begin
                flags_next.run    = 1'b0;
                flags_next.susp   = 1'b1;
                last_level_next   = '0;
                origin_rate_next  = '0;
                present_rate_next = '0;
                target_rate_next  = '0;
              end
            end else if (present_rate_next != '0) begin
              if (flags.susp) begin
                flags_next.en   = 1'b1;
                flags_next.susp = 1'b0;
              end
            end else begin
              flags_next.run    = 1'b0;
              flags_next.susp   = 1'b1;
              last_level_next   = '0;
              origin_rate_next  = '0;
              present_rate_next = '0;
              target_rate_next  = '0;
            end
          end else if (target_rate == origin_rate) begin
            flags_next.run = 1'b0;
          end else begin
            present_rate_next = curve;
            ramp_pos_next     = pos_inc;
            if (target_rate == '0) begin
              flags_next.run    = 1'b0;
              flags_next.susp   = 1'b1;
              last_level_next   = '0;
              origin_rate_next  = '0;
              present_rate_next = '0;
              target_rate_next  = '0;
            end else begin
              if (flags.susp) begin
                flags_next.en   = 1'b1;
                flags_next.susp = 1'b0;
              end
              if (pos_inc > POS_HALF) begin
                flags_next.run    = 1'b0;
                origin_rate_next  = target_rate;
                present_rate_next = target_rate;
              end
            end
          end
        end
      end
      ST_MEAN: mean_q_next = mean_calc;
      ST_CHECK: begin
        if (take) begin
          last_level_next = mean_q;
          flags_next.run  = 1'b1;
        end
      end
      ST_PCT: begin
        pct_q_next = (pct_shift > (2*DATA_W+1)'(FULL_SCALE_PCT)) ?
                     PCT_W'(FULL_SCALE_PCT) : PCT_W'(pct_shift);
      end
      ST_MUL: prod_q_next = PROD_W'(max_step_rate) * PROD_W'(pct_q);
      ST_DIV: begin
        target_rate_next = div_tgt;
        if (div_tgt < present_rate) begin
          flags_next.fall = 1'b1;
          ramp_pos_next   = POS_HALF;
        end else begin
          flags_next.fall = 1'b0;
          ramp_pos_next   = POS_NEG_HALF;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // --- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= CHANGE_THRESHOLD_RST;
      max_step_rate    <= MAX_STEP_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_wdata;
        REG_MAX_STEP_RATE:    max_step_rate    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      req_vld      <= 1'b0;
      out_valid    <= 1'b0;
      win_vld      <= '0;
      old_vld      <= 1'b0;
      win_ptr      <= '0;
      win_sum      <= '0;
      last_level   <= '0;
      target_rate  <= '0;
      present_rate <= '0;
      origin_rate  <= '0;
      ramp_pos     <= POS_NEG_HALF;
      flags        <= FLAGS_RST;
    end else begin
      state        <= state_next;
      win_ptr      <= win_ptr_next;
      win_sum      <= win_sum_next;
      last_level   <= last_level_next;
      target_rate  <= target_rate_next;
      present_rate <= present_rate_next;
      origin_rate  <= origin_rate_next;
      ramp_pos     <= ramp_pos_next;
      flags        <= flags_next;

      if (in_valid && in_ready) begin
        req_vld <= 1'b1;
      end else if (complete) begin
        req_vld <= 1'b0;
      end

      if (complete) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (win_go) win_vld[win_ptr] <= 1'b1;
      old_vld <= win_vld[win_ptr_next];
    end
  end

  // window RAM: write the new sample, prefetch the entry it will replace next
  always_ff @(posedge clk) begin
    if (win_go) win_mem[win_ptr] <= req.adc_sample;
    old_data <= win_mem[win_ptr_next];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req <= in_data;
    mean_q <= mean_q_next;
    pct_q  <= pct_q_next;
    prod_q <= prod_q_next;
    if (complete) begin
      out_data.step_rate      <= present_rate_next;
      out_data.pulses_on      <= !flags_next.susp;
      out_data.motor_enabled  <= flags_next.en;
      out_data.direction_down <= flags_next.dir;
      out_data.ramp_active    <= flags_next.run;
    end
  end

endmodule

>>> rtl/ssrr_checker.sv
`include "sigmoid_step_rate_ramp_core_macros.svh"

module ssrr_checker import ssrr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  logic       in_acc, out_acc;
  logic [1:0] pending;    // requests taken but not yet answered
  logic       en_seen;    // an enabled response has gone out

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      en_seen <= 1'b0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
      if (out_acc && out_data.motor_enabled) en_seen <= 1'b1;
    end
  end

  `SSRR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `SSRR_ASSERT_NOW(a_no_spurious_rsp, clk, rst, out_acc, pending != 2'd0)
  `SSRR_ASSERT_NOW(a_idle_ready, clk, rst, pending == 2'd0, in_ready)
  `SSRR_ASSERT_NOW(a_pulse_needs_en, clk, rst, out_valid, !out_data.pulses_on || out_data.motor_enabled)
  `SSRR_ASSERT_NOW(a_en_sticky, clk, rst, out_valid && en_seen, out_data.motor_enabled)

endmodule

bind sigmoid_step_rate_ramp_core ssrr_checker u_ssrr_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

>>> tb/sigmoid_step_rate_ramp_core_test.sv
`timescale 1ns / 1ps

module sigmoid_step_rate_ramp_core_test;
  import ssrr_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rsp_t                 out_data;

  sigmoid_step_rate_ramp_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Speed controller model: own copy of window, ramp state and registers.
  // ---------------------------------------------------------------------------

  // Q16 logistic weights, t = -20 .. 20
  localparam int unsigned LOGISTIC_Q16 [2*SIG_HALF+1] = '{
    1179, 1434, 1743, 2117, 2567, 3108, 3757, 4531, 5451, 6537,
    7812, 9296, 11009, 12964, 15170, 17625, 20318, 23222, 26300, 29502,
    32768,
    36034, 39236, 42314, 45218, 47911, 50366, 52572, 54527, 56240, 57724,
    58999, 60085, 61005, 61779, 62428, 62969, 63419, 63793, 64102, 64357
  };

  localparam rsp_t RSP_AT_REST = '{step_rate: '0, pulses_on: 1'b0, motor_enabled: 1'b0,
                                   direction_down: 1'b0, ramp_active: 1'b0};

  logic [DATA_W-1:0] knob_hist [WINDOW_LEN];
  int unsigned       knob_ptr;
  int unsigned       knob_total;
  int unsigned       level_taken;
  int unsigned       goal_rate;
  int unsigned       now_rate;
  int unsigned       base_rate;
  int                curve_pos;
  flags_t            drv;
  int unsigned       thr_reg;
  int unsigned       max_reg;

  function automatic void model_reset();
    foreach (knob_hist[i]) knob_hist[i] = '0;
    knob_ptr    = 0;
    knob_total  = 0;
    level_taken = 0;
    goal_rate   = 0;
    now_rate    = 0;
    base_rate   = 0;
    curve_pos   = -RAMP_HALF_STEPS;
    drv         = FLAGS_RST;
    thr_reg     = 32'(CHANGE_THRESHOLD_RST);
    max_reg     = 32'(MAX_STEP_RATE_RST);
  endfunction

  // Rising: from s toward d. Otherwise the scaled gap only, no base added.
  function automatic int unsigned s_curve(int unsigned d, int unsigned s, int t);
    int                k;
    longint unsigned   w;
    longint unsigned   gap;
    k = t;
    if (k < -SIG_HALF) k = -SIG_HALF;
    if (k > SIG_HALF)  k = SIG_HALF;
    w = LOGISTIC_Q16[k + SIG_HALF];
    if (d > s) begin
      gap = d - s;
      return ((gap * w) >> 16) + s;
    end
    gap = s - d;
    return (gap * w) >> 16;
  endfunction

  function automatic void halt_drive();
    drv.run     = 1'b0;
    drv.susp    = 1'b1;
    level_taken = 0;
    base_rate   = 0;
    now_rate    = 0;
    goal_rate   = 0;
  endfunction

  function automatic void wake_pulses();
    if (drv.susp) begin
      drv.en   = 1'b1;
      drv.susp = 1'b0;
    end
  endfunction

  function automatic void land_ramp();
    drv.run   = 1'b0;
    base_rate = goal_rate;
    now_rate  = goal_rate;
  endfunction

  function automatic void pick_goal(int unsigned mean);
    int unsigned diff;
    int unsigned pct;
    diff = (mean > level_taken) ? mean - level_taken : level_taken - mean;
    // under one percent with a live target always counts as a change
    if (diff > thr_reg || (mean < COUNTS_PER_PERCENT && goal_rate != 0)) begin
      pct = mean / COUNTS_PER_PERCENT;
      if (pct > FULL_SCALE_PCT) pct = FULL_SCALE_PCT;
      level_taken = mean;
      goal_rate   = (max_reg * pct) / FULL_SCALE_PCT;
      if (goal_rate < now_rate) begin
        drv.fall  = 1'b1;
        curve_pos = RAMP_HALF_STEPS;
      end else begin
        drv.fall  = 1'b0;
        curve_pos = -RAMP_HALF_STEPS;
      end
      drv.run = 1'b1;
    end
  endfunction

  function automatic void knob_pass(logic [DATA_W-1:0] sample, logic up, logic dn);
    int unsigned mean;
    if (knob_ptr >= WINDOW_LEN) knob_ptr = 0;
    knob_total = knob_total - knob_hist[knob_ptr] + sample;
    knob_hist[knob_ptr] = sample;
    knob_ptr++;
    if (knob_ptr >= WINDOW_LEN) knob_ptr = 0;
    mean = knob_total / WINDOW_LEN;
    if (up || dn) begin
      if (!drv.run) begin
        // both held counts as up
        if (up) begin
          drv.dir      = 1'b0;
          drv.up_latch = 1'b1;
        end else begin
          drv.dir      = 1'b1;
          drv.dn_latch = 1'b1;
        end
        pick_goal(mean);
      end
    end else if (drv.up_latch || drv.dn_latch) begin
      // release: ramp down to standstill
      goal_rate    = 0;
      curve_pos    = RAMP_HALF_STEPS;
      drv.run      = 1'b1;
      drv.fall     = 1'b1;
      drv.up_latch = 1'b0;
      drv.dn_latch = 1'b0;
    end
  endfunction

  function automatic void climb_tick();
    if (goal_rate == base_rate) begin
      drv.run = 1'b0;
      return;
    end
    now_rate = s_curve(goal_rate, base_rate, curve_pos) & 32'h0000_FFFF;
    curve_pos++;
    if (goal_rate == 0) begin
      halt_drive();
      return;
    end
    wake_pulses();
    if (curve_pos > RAMP_HALF_STEPS) land_ramp();
  endfunction

  function automatic void descend_tick();
    int unsigned v;
    v = goal_rate + s_curve(goal_rate, base_rate, curve_pos);
    now_rate = (v > 32'h0000_FFFF) ? 32'h0000_FFFF : v;   // saturating sum
    curve_pos--;
    if (curve_pos < -RAMP_HALF_STEPS) begin
      if (goal_rate > 0) begin
        wake_pulses();
        land_ramp();
      end else begin
        halt_drive();
      end
    end else if (now_rate > 0) begin
      wake_pulses();
    end else begin
      halt_drive();
    end
  endfunction

  function automatic rsp_t step_drive(req_t r);
    rsp_t o;
    if (r.func == FUNC_TICK) begin
      // a tick with no ramp running leaves everything alone
      if (drv.run) begin
        if (drv.fall) descend_tick();
        else climb_tick();
      end
    end else begin
      knob_pass(r.adc_sample, r.up_pressed, r.down_pressed);
    end
    o.step_rate      = DATA_W'(now_rate);
    o.pulses_on      = !drv.susp;
    o.motor_enabled  = drv.en;
    o.direction_down = drv.dir;
    o.ramp_active    = drv.run;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: responses due, oldest first.
  // ---------------------------------------------------------------------------
  rsp_t drive_due_q [$];
  int   fail_count  = 0;
  int   items_done  = 0;
  int   burst_left  = 0;
  int   hold_off_count = 0;

  always @(posedge clk) begin
    rsp_t due;
    if (!rst && out_valid && out_ready) begin
      if (drive_due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: response with none due: rate %0d", $realtime, out_data.step_rate);
      end else begin
        due = drive_due_q.pop_front();
        if (due.step_rate      !== out_data.step_rate      ||
            due.pulses_on      !== out_data.pulses_on      ||
            due.motor_enabled  !== out_data.motor_enabled  ||
            due.direction_down !== out_data.direction_down ||
            due.ramp_active    !== out_data.ramp_active) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch exp rate %0d on %b en %b dn %b act %b, got %0d %b %b %b %b",
                     $realtime, due.step_rate, due.pulses_on, due.motor_enabled,
                     due.direction_down, due.ramp_active, out_data.step_rate,
                     out_data.pulses_on, out_data.motor_enabled, out_data.direction_down,
                     out_data.ramp_active);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: out_ready follows one of four patterns, picked anew at random; on
  // request it holds off for a long stretch so the block backs up.
  // ---------------------------------------------------------------------------
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  initial begin
    rx_mode_t    rx_mode;
    int          mode_left;
    int          hold_left;
    int          hold_seen;
    int unsigned beat;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    beat      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_count != hold_seen) begin
        hold_seen = hold_off_count;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        beat++;
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (beat % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Bursts of random length with random gaps in between; valid
  // stays up from one request to the next within a burst.
  // ---------------------------------------------------------------------------
  task automatic push_request(input req_t r, input bit typed, input rsp_t want);
    int   gap;
    rsp_t due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    items_done++;
    due = step_drive(r);
    if (typed) due = want;
    drive_due_q.push_back(due);
  endtask

  // Drop valid, let every due response drain, then allow for pipeline slack.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_due_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_CHANGE_THRESHOLD) thr_reg = 32'(val);
    else max_reg = 32'(val);
  endtask

  function automatic req_t knob_req(logic [DATA_W-1:0] adc, logic up, logic dn);
    req_t r;
    r.func         = FUNC_CONTROL;
    r.adc_sample   = adc;
    r.up_pressed   = up;
    r.down_pressed = dn;
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r = '0;
    r.func = FUNC_TICK;
    return r;
  endfunction

  // Typical use: hold a button on a knob level long enough to fill part or all of
  // the window, tick the ramp along, release, tick down to standstill.
  task automatic run_gesture();
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] sample;
    logic              up;
    logic              dn;
    int                fill;
    int                n;
    case ($urandom_range(0, 3))
      0:       level = 16'hFFFF;
      1:       level = DATA_W'($urandom_range(0, 600));   // around one percent
      2:       level = DATA_W'($urandom);
      default: level = DATA_W'($urandom_range(0, 41800));
    endcase
    case ($urandom_range(0, 2))
      0:       begin up = 1'b1; dn = 1'b0; end
      1:       begin up = 1'b0; dn = 1'b1; end
      default: begin up = 1'b1; dn = 1'b1; end
    endcase
    fill = $urandom_range(3, 40);
    for (int i = 0; i < fill; i++) begin
      sample = ($urandom_range(0, 3) == 0) ? level ^ DATA_W'($urandom_range(0, 255)) : level;
      push_request(knob_req(sample, up, dn), 1'b0, RSP_AT_REST);
      if ($urandom_range(0, 3) == 0) push_request(tick_req(), 1'b0, RSP_AT_REST);
    end
    n = $urandom_range(5, 45);
    repeat (n) push_request(tick_req(), 1'b0, RSP_AT_REST);
    if ($urandom_range(0, 7) != 0)
      push_request(knob_req(level, 1'b0, 1'b0), 1'b0, RSP_AT_REST);
    n = $urandom_range(5, 45);
    repeat (n) push_request(tick_req(), 1'b0, RSP_AT_REST);
  endtask

  // Unstructured requests: any field, any mix.
  task automatic run_noise();
    req_t r;
    int   n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      r.func         = 1'($urandom_range(0, 1));
      r.adc_sample   = DATA_W'($urandom);
      r.up_pressed   = 1'($urandom_range(0, 1));
      r.down_pressed = 1'($urandom_range(0, 1));
      push_request(r, 1'b0, RSP_AT_REST);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed opening. Only the rows at rest are typed in; the rest go
  // through the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] adc;
    logic              up;
    logic              dn;
    logic              typed;
    rsp_t              want;
  } step_row_t;

  localparam int OPENING_LEN = 24;
  localparam step_row_t OPENING [OPENING_LEN] = '{
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b1, RSP_AT_REST},  // tick straight out of reset
    '{FUNC_CONTROL, 16'h0000, 1'b0, 1'b0, 1'b1, RSP_AT_REST},  // no button: nothing taken
    '{FUNC_CONTROL, 16'hFFFF, 1'b0, 1'b0, 1'b1, RSP_AT_REST},
    '{FUNC_CONTROL, 16'hFFFF, 1'b1, 1'b1, 1'b0, RSP_AT_REST},  // both held reads as up
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'hFFFF, 1'b0, 1'b1, 1'b0, RSP_AT_REST},  // button during a ramp
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},  // release mid climb
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'hFFFF, 1'b0, 1'b1, 1'b0, RSP_AT_REST},  // down direction
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'h8000, 1'b1, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'h01A1, 1'b1, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'h5555, 1'b0, 1'b1, 1'b0, RSP_AT_REST},
    '{FUNC_CONTROL, 16'hAAAA, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST},
    '{FUNC_TICK,    16'h0000, 1'b0, 1'b0, 1'b0, RSP_AT_REST}
  };

  // ---------------------------------------------------------------------------
  // Main sequence: reset, opening rows, then random phases under several
  // register settings (extremes included), each written while idle.
  // ---------------------------------------------------------------------------
  localparam int PHASES        = 6;
  localparam int PHASE_REQUESTS = 75;

  initial begin
    req_t r;
    int   phase_goal;
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_LEN; i++) begin
      r.func         = OPENING[i].func;
      r.adc_sample   = OPENING[i].adc;
      r.up_pressed   = OPENING[i].up;
      r.down_pressed = OPENING[i].dn;
      push_request(r, OPENING[i].typed, OPENING[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: ;                                            // reset settings
        1: begin
          write_reg(REG_CHANGE_THRESHOLD, 16'h0000);
          write_reg(REG_MAX_STEP_RATE, 16'hFFFF);
        end
        2: begin
          write_reg(REG_CHANGE_THRESHOLD, 16'hFFFF);
          write_reg(REG_MAX_STEP_RATE, 16'h0000);
        end
        3: begin
          write_reg(REG_CHANGE_THRESHOLD, 16'h0000);
          write_reg(REG_MAX_STEP_RATE, 16'd12000);
        end
        4: begin
          write_reg(REG_CHANGE_THRESHOLD, DATA_W'($urandom_range(0, 3000)));
          write_reg(REG_MAX_STEP_RATE, DATA_W'($urandom));
        end
        default: begin
          write_reg(REG_CHANGE_THRESHOLD, 16'hFFFF);
          write_reg(REG_MAX_STEP_RATE, 16'hFFFF);
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (p == 1 || p == 4) hold_off_count++;
      phase_goal = items_done + PHASE_REQUESTS;
      while (items_done < phase_goal) begin
        if ($urandom_range(0, 3) != 0) run_gesture();
        else run_noise();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && drive_due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
